// ----- sv/bad_block_table_remap_assert.svh -----
// Assertion macros for the bad block table remap block.
// Included by the top level; depends on clk and rst_n in the including scope.
`ifndef BAD_BLOCK_TABLE_REMAP_ASSERT_SVH
`define BAD_BLOCK_TABLE_REMAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bbt_pkg.sv -----
// Shared types, sizes and codes for the bad block table remap block.
// No dependencies; used by every module of the block.
package bbt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int PAGE_BITS   = 24;
  localparam int MAPPED_W    = PAGE_BITS + 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LOG2_W      = 4;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam logic [LOG2_W-1:0] MAX_BLOCK_LOG2 = 4'd8;

  // Command codes.
  localparam logic [2:0] CMD_MARK     = 3'd0;
  localparam logic [2:0] CMD_REGISTER = 3'd1;
  localparam logic [2:0] CMD_QUERY    = 3'd2;
  localparam logic [2:0] CMD_REMAP    = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_DUP    = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_LOCKED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_DONE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUNTIME_REG = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_QUERY,
    OP_REMAP
  } op_t;

  typedef struct packed {
    logic              block_mode;
    logic [LOG2_W-1:0] block_pages_log2;
    logic              scan_complete;
    logic              runtime_register_enable;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [PAGE_BITS-1:0] wdata;
    logic [IDX_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic [MAPPED_W-1:0] key;
    logic [MAPPED_W-1:0] step;
  } alu_req_t;

  typedef struct packed {
    logic                lt;
    logic                eq;
    logic                gt;
    logic [MAPPED_W-1:0] sum;
  } alu_res_t;

endpackage

// ----- sv/bbt_mem.sv -----
// Table storage: one write port and one registered read port.
// Depends on bbt_pkg for depth, widths and the request struct.
module bbt_mem (
  input  logic                          clk,
  input  bbt_pkg::mem_req_t             req,
  output logic [bbt_pkg::PAGE_BITS-1:0] rdata
);

  logic [bbt_pkg::PAGE_BITS-1:0] mem [bbt_pkg::TABLE_DEPTH];
  logic [bbt_pkg::PAGE_BITS-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bbt_alu.sv -----
// Shared compare and saturating step unit used on every table walk.
// Depends on bbt_pkg for widths and the request and result structs.
module bbt_alu (
  input  logic [bbt_pkg::PAGE_BITS-1:0] entry,
  input  bbt_pkg::alu_req_t             req,
  output bbt_pkg::alu_res_t             res
);

  logic [bbt_pkg::MAPPED_W-1:0] entry_ext;
  logic [bbt_pkg::MAPPED_W:0]   sum_wide;

  // Compare the table entry against the search key or running page.
  assign entry_ext = bbt_pkg::MAPPED_W'(entry);
  assign res.lt    = entry_ext < req.key;
  assign res.eq    = entry_ext == req.key;
  assign res.gt    = entry_ext > req.key;

  // Advance the running page, saturating at the all-ones value.
  assign sum_wide = {1'b0, req.key} + {1'b0, req.step};
  assign res.sum  = sum_wide[bbt_pkg::MAPPED_W] ? '1 : sum_wide[bbt_pkg::MAPPED_W-1:0];

endmodule

// ----- sv/bbt_ctrl.sv -----
// Command sequencer: walks the table one entry per cycle for insert, query and remap.
// Depends on bbt_pkg; drives bbt_mem and bbt_alu through structs.
module bbt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2:0]                    in_command,
  input  logic [bbt_pkg::PAGE_BITS-1:0] in_page_number,
  input  bbt_pkg::cfg_t                 cfg,
  input  logic [bbt_pkg::PAGE_BITS-1:0] rdata,
  input  bbt_pkg::alu_res_t             alu_res,
  output logic                          busy,
  output bbt_pkg::mem_req_t             mem_req,
  output bbt_pkg::alu_req_t             alu_req,
  output logic                          clear_scan,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic                          out_is_bad,
  output logic [bbt_pkg::MAPPED_W-1:0]  out_mapped_page,
  output logic [bbt_pkg::CNT_W-1:0]     out_entry_count
);

  bbt_pkg::state_t               state_r, state_nxt;
  bbt_pkg::op_t                  op_r, op_nxt;
  logic [bbt_pkg::MAPPED_W-1:0]  key_r, key_nxt;
  logic [bbt_pkg::PAGE_BITS-1:0] carry_r, carry_nxt;
  logic                          shift_r, shift_nxt;
  logic [bbt_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [bbt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                          strobe_r, strobe_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic                          is_bad_r, is_bad_nxt;
  logic [bbt_pkg::MAPPED_W-1:0]  mapped_r, mapped_nxt;
  logic [bbt_pkg::CNT_W-1:0]     ecount_r, ecount_nxt;

  logic [bbt_pkg::LOG2_W-1:0]    eff_log2;
  logic [bbt_pkg::PAGE_BITS-1:0] low_mask;
  logic [bbt_pkg::PAGE_BITS-1:0] aligned;
  logic [bbt_pkg::CNT_W-1:0]     idx_inc;
  logic                          have;
  logic                          fin;
  logic [1:0]                    fin_status;
  logic                          fin_bad;
  logic [bbt_pkg::MAPPED_W-1:0]  fin_mapped;

  // Block size, page alignment and remap step from the current configuration.
  assign eff_log2 = (cfg.block_pages_log2 > bbt_pkg::MAX_BLOCK_LOG2) ?
                    bbt_pkg::MAX_BLOCK_LOG2 : cfg.block_pages_log2;
  assign low_mask = (bbt_pkg::PAGE_BITS'(1) << eff_log2) - bbt_pkg::PAGE_BITS'(1);
  assign aligned  = cfg.block_mode ? (in_page_number & ~low_mask) : in_page_number;
  assign alu_req.step = cfg.block_mode ? (bbt_pkg::MAPPED_W'(1) << eff_log2) :
                        bbt_pkg::MAPPED_W'(1);
  assign alu_req.key  = key_r;

  // Walk position; the entry at idx_r is on rdata while idx_r is below the count.
  assign idx_inc = idx_r + bbt_pkg::CNT_W'(1);
  assign have    = idx_r < count_r;
  assign busy    = (state_r != bbt_pkg::ST_IDLE);

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bbt_pkg::ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      shift_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      shift_r  <= shift_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    carry_r  <= carry_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    is_bad_r <= is_bad_nxt;
    mapped_r <= mapped_nxt;
    ecount_r <= ecount_nxt;
  end

  // Next state, memory requests and result capture.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    carry_nxt  = carry_r;
    shift_nxt  = shift_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    is_bad_nxt = is_bad_r;
    mapped_nxt = mapped_r;
    ecount_nxt = ecount_r;
    strobe_nxt = 1'b0;
    clear_scan = 1'b0;
    fin        = 1'b0;
    fin_status = bbt_pkg::STAT_DONE;
    fin_bad    = 1'b0;
    fin_mapped = '0;

    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r[bbt_pkg::IDX_W-1:0];
    mem_req.wdata = key_r[bbt_pkg::PAGE_BITS-1:0];
    mem_req.raddr = '0;

    case (state_r)
      bbt_pkg::ST_IDLE: begin
        // Entry zero is read now so the walk can compare it in its first cycle.
        if (start) begin
          idx_nxt   = '0;
          shift_nxt = 1'b0;
          case (in_command)
            bbt_pkg::CMD_MARK, bbt_pkg::CMD_REGISTER: begin
              // A locked register is refused before the table is looked at.
              if ((in_command == bbt_pkg::CMD_REGISTER) &&
                  cfg.scan_complete && !cfg.runtime_register_enable) begin
                fin        = 1'b1;
                fin_status = bbt_pkg::STAT_LOCKED;
              end else if (count_r >= bbt_pkg::CNT_W'(bbt_pkg::TABLE_DEPTH)) begin
                fin        = 1'b1;
                fin_status = bbt_pkg::STAT_FULL;
              end else begin
                op_nxt    = bbt_pkg::OP_INSERT;
                key_nxt   = bbt_pkg::MAPPED_W'(aligned);
                state_nxt = bbt_pkg::ST_WALK;
              end
            end
            bbt_pkg::CMD_QUERY: begin
              op_nxt    = bbt_pkg::OP_QUERY;
              key_nxt   = bbt_pkg::MAPPED_W'(aligned);
              state_nxt = bbt_pkg::ST_WALK;
            end
            bbt_pkg::CMD_REMAP: begin
              op_nxt    = bbt_pkg::OP_REMAP;
              key_nxt   = bbt_pkg::MAPPED_W'(in_page_number);
              state_nxt = bbt_pkg::ST_WALK;
            end
            bbt_pkg::CMD_CLEAR: begin
              count_nxt  = '0;
              clear_scan = 1'b1;
              fin        = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      bbt_pkg::ST_WALK: begin
        // Fetch the next entry while the current one is evaluated.
        mem_req.raddr = idx_inc[bbt_pkg::IDX_W-1:0];
        case (op_r)
          bbt_pkg::OP_INSERT: begin
            if (have) begin
              if (shift_r) begin
                // Ripple: each entry moves up one place, carried through a register.
                mem_req.we    = 1'b1;
                mem_req.wdata = carry_r;
                carry_nxt     = rdata;
                idx_nxt       = idx_inc;
              end else if (alu_res.lt) begin
                idx_nxt = idx_inc;
              end else if (alu_res.eq) begin
                fin        = 1'b1;
                fin_status = bbt_pkg::STAT_DUP;
              end else begin
                // First larger entry: the new page takes its place.
                mem_req.we = 1'b1;
                carry_nxt  = rdata;
                shift_nxt  = 1'b1;
                idx_nxt    = idx_inc;
              end
            end else begin
              // End of table: write the last carried entry or the new page.
              mem_req.we    = 1'b1;
              mem_req.wdata = shift_r ? carry_r : key_r[bbt_pkg::PAGE_BITS-1:0];
              count_nxt     = count_r + bbt_pkg::CNT_W'(1);
              fin           = 1'b1;
            end
          end
          bbt_pkg::OP_QUERY: begin
            if (have && alu_res.lt) begin
              idx_nxt = idx_inc;
            end else begin
              fin     = 1'b1;
              fin_bad = have && alu_res.eq;
            end
          end
          bbt_pkg::OP_REMAP: begin
            if (have && !alu_res.gt) begin
              key_nxt = alu_res.sum;
              idx_nxt = idx_inc;
            end else begin
              fin        = 1'b1;
              fin_mapped = key_r;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      default: begin
        state_nxt = bbt_pkg::ST_IDLE;
      end
    endcase

    // Capture the result beat.
    if (fin) begin
      state_nxt  = bbt_pkg::ST_IDLE;
      strobe_nxt = 1'b1;
      status_nxt = fin_status;
      is_bad_nxt = fin_bad;
      mapped_nxt = fin_mapped;
      ecount_nxt = count_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_is_bad      = is_bad_r;
  assign out_mapped_page = mapped_r;
  assign out_entry_count = ecount_r;

endmodule

// ----- sv/bad_block_table_remap.sv -----
// Top level of the bad block table remap block: configuration registers and wiring.
// Depends on bbt_pkg, bbt_mem, bbt_alu, bbt_ctrl and the assertion macro header.
//
// A command is taken when start is high and busy is low; its result beat appears on
// the out_ ports for one cycle with out_strobe, and the receiver cannot stall it.
// Busy is already low in the cycle the strobe is shown, so the next command may start
// there. Clear, unknown commands and refused inserts (table full, registration
// locked) finish from idle without a table walk. Query, remap, mark and register
// walk the table up to the entry count: the sequencer visits one table entry per
// cycle through the single read port of the table memory, comparing it in the
// shared compare and step unit. The table memory needs no clearing pass; entries
// at or above the count are never read as data.
`include "bad_block_table_remap_assert.svh"

module bad_block_table_remap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_command,
  input  logic [bbt_pkg::PAGE_BITS-1:0]     in_page_number,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic                              out_is_bad,
  output logic [bbt_pkg::MAPPED_W-1:0]      out_mapped_page,
  output logic [bbt_pkg::CNT_W-1:0]         out_entry_count,
  input  logic                              cfg_we,
  input  logic [bbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbt_pkg::CFG_W-1:0]         cfg_data
);

  bbt_pkg::cfg_t                 cfg_r, cfg_nxt;
  bbt_pkg::mem_req_t             mem_req;
  bbt_pkg::alu_req_t             alu_req;
  bbt_pkg::alu_res_t             alu_res;
  logic [bbt_pkg::PAGE_BITS-1:0] rdata;
  logic                          clear_scan;

  // Configuration write decode; clear also drops the scan-complete flag.
  always_comb begin
    cfg_nxt = cfg_r;
    if (clear_scan) begin
      cfg_nxt.scan_complete = 1'b0;
    end
    if (cfg_we) begin
      case (cfg_index)
        bbt_pkg::REG_BLOCK_MODE:  cfg_nxt.block_mode              = cfg_data[0];
        bbt_pkg::REG_BLOCK_LOG2:  cfg_nxt.block_pages_log2        = cfg_data;
        bbt_pkg::REG_SCAN_DONE:   cfg_nxt.scan_complete           = cfg_data[0];
        bbt_pkg::REG_RUNTIME_REG: cfg_nxt.runtime_register_enable = cfg_data[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_mode              <= 1'b1;
      cfg_r.block_pages_log2        <= 4'd6;
      cfg_r.scan_complete           <= 1'b0;
      cfg_r.runtime_register_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer.
  bbt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_command      (in_command),
    .in_page_number  (in_page_number),
    .cfg             (cfg_r),
    .rdata           (rdata),
    .alu_res         (alu_res),
    .busy            (busy),
    .mem_req         (mem_req),
    .alu_req         (alu_req),
    .clear_scan      (clear_scan),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_is_bad      (out_is_bad),
    .out_mapped_page (out_mapped_page),
    .out_entry_count (out_entry_count)
  );

  // Table memory.
  bbt_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Shared compare and step unit.
  bbt_alu u_alu (
    .entry (rdata),
    .req   (alu_req),
    .res   (alu_res)
  );

  // Assertions.
  `BBT_ASSERT_SAME(a_strobe_idle, out_strobe, !busy, "result beat while busy")
  `BBT_ASSERT_SAME(a_count_range, out_strobe, out_entry_count <= bbt_pkg::CNT_W'(bbt_pkg::TABLE_DEPTH), "entry count above table depth")
  `BBT_ASSERT_SAME(a_side_zero, out_strobe && (out_status != bbt_pkg::STAT_DONE), !out_is_bad && (out_mapped_page == '0), "query or remap field set on insert status")
  `BBT_ASSERT_NEXT(a_clear_empty, start && !busy && (in_command == bbt_pkg::CMD_CLEAR), out_strobe && (out_entry_count == '0), "clear did not empty the table")

endmodule
